FILE: design/vpd_pkg.sv
package vpd_pkg;

  // Header layout: 24 bytes, little endian
  localparam int unsigned HDR_BYTES = 24;
  localparam int unsigned HDR_IDX_W = 5;

  // Byte counter, saturating
  localparam int unsigned COUNT_W = 17;
  localparam logic [COUNT_W-1:0] COUNT_MAX = {COUNT_W{1'b1}};

  // Result queue
  localparam int unsigned QUEUE_DEPTH = 4;
  localparam int unsigned QPTR_W = 2;
  localparam int unsigned QCNT_W = 3;

  // Result kinds
  localparam logic KIND_PAYLOAD = 1'b0;
  localparam logic KIND_VERDICT = 1'b1;

  // Verdict status codes, in priority order after OK
  localparam logic [2:0] ST_OK        = 3'd0;
  localparam logic [2:0] ST_SHORT     = 3'd1;
  localparam logic [2:0] ST_BAD_MAGIC = 3'd2;
  localparam logic [2:0] ST_BAD_VER   = 3'd3;
  localparam logic [2:0] ST_BAD_LEN   = 3'd4;
  localparam logic [2:0] ST_SIZE_MISM = 3'd5;

  // Configuration register indexes
  localparam int unsigned REG_IDX_W = 2;
  localparam logic [REG_IDX_W-1:0] REG_MAGIC_WORD   = 2'd0;
  localparam logic [REG_IDX_W-1:0] REG_EXP_VERSION  = 2'd1;
  localparam logic [REG_IDX_W-1:0] REG_MAX_PAYLOAD  = 2'd2;

  localparam logic [31:0] MAGIC_RESET   = 32'd0;
  localparam logic [7:0]  VERSION_RESET = 8'd1;
  localparam logic [15:0] MAX_PAY_RESET = 16'd1275;

  typedef struct packed {
    logic        kind;
    logic [7:0]  payload_byte;
    logic [2:0]  status;
    logic [7:0]  flags;
    logic [15:0] payload_length;
    logic [31:0] room_id;
    logic [31:0] source_id;
    logic [31:0] sequence_number;
    logic [31:0] time_stamp;
    logic        end_of_run;
  } result_t;

endpackage

FILE: design/voice_packet_deframer_unit.sv
// Voice packet deframer. Takes a packet one byte per word on the input channel,
// with end_of_packet set on its last byte. The first 24 bytes are a
// little-endian header (magic, version, flags, payload length, room, sender,
// sequence, timestamp); every later byte comes out as a payload result
// (result_kind 0). The last byte also yields one verdict result (result_kind 1)
// carrying the header fields and a status: short, bad magic, bad version, bad
// length field, size mismatch, in that priority, or ok. When the last byte lies
// in the payload, its payload result comes first, then the verdict. Rate: one
// input byte per clock while out_ready is high. Each byte is handled in the
// cycle it is accepted and its results are registered into the queue. Results
// leave through a four-entry queue, one per clock while taken; the queue absorbs
// the extra verdict at the end of a packet, and input is held off only when it
// cannot take two more results. Configuration writes take effect at once and are
// always accepted (cfg_ready is tied high); write only between packets.
module voice_packet_deframer_unit (
  input  logic        clk,
  input  logic        rst,
  // byte input
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  data_byte,
  input  logic        end_of_packet,
  // result output
  output logic        out_valid,
  input  logic        out_ready,
  output logic        result_kind,
  output logic [7:0]  payload_byte,
  output logic [2:0]  status,
  output logic [7:0]  flags,
  output logic [15:0] payload_length,
  output logic [31:0] room_id,
  output logic [31:0] source_id,
  output logic [31:0] sequence_number,
  output logic [31:0] time_stamp,
  output logic        end_of_run,
  // configuration writes
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [vpd_pkg::REG_IDX_W-1:0] cfg_index,
  input  logic [31:0] cfg_data
);

  // Configuration registers
  logic [31:0] magic_word;
  logic [7:0]  expected_version;
  logic [15:0] max_payload;

  // Packet state
  logic [vpd_pkg::COUNT_W-1:0] byte_count;
  logic [7:0] hdr [vpd_pkg::HDR_BYTES];

  // Result queue
  vpd_pkg::result_t queue [vpd_pkg::QUEUE_DEPTH];
  logic [vpd_pkg::QPTR_W-1:0] wr_ptr;
  logic [vpd_pkg::QPTR_W-1:0] rd_ptr;
  logic [vpd_pkg::QCNT_W-1:0] q_count;

  // Per-byte datapath
  logic                        in_acc;
  logic                        pop;
  logic                        in_header;
  logic [vpd_pkg::COUNT_W-1:0] count_inc;
  logic [7:0]                  hdr_next [vpd_pkg::HDR_BYTES];
  logic [31:0]                 magic_next;
  logic [15:0]                 length_next;
  logic [2:0]                  verdict_status;
  vpd_pkg::result_t            payload_res;
  vpd_pkg::result_t            verdict_res;
  vpd_pkg::result_t            first_res;
  logic [vpd_pkg::QCNT_W-1:0]  n_results;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      magic_word       <= vpd_pkg::MAGIC_RESET;
      expected_version <= vpd_pkg::VERSION_RESET;
      max_payload      <= vpd_pkg::MAX_PAY_RESET;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        vpd_pkg::REG_MAGIC_WORD:  magic_word       <= cfg_data;
        vpd_pkg::REG_EXP_VERSION: expected_version <= cfg_data[7:0];
        vpd_pkg::REG_MAX_PAYLOAD: max_payload      <= cfg_data[15:0];
        default: ;  // unknown index: drop the write
      endcase
    end
  end

  // Queue handshake: pop the head when taken; take a byte only when two
  // results still fit after this cycle's pop.
  assign out_valid = (q_count != '0);
  assign pop       = out_valid && out_ready;
  assign in_ready  = (q_count < vpd_pkg::QCNT_W'(vpd_pkg::QUEUE_DEPTH - 1)) ||
                     ((q_count == vpd_pkg::QCNT_W'(vpd_pkg::QUEUE_DEPTH - 1)) && out_ready);
  assign in_acc    = in_valid && in_ready;

  assign in_header = (byte_count < vpd_pkg::COUNT_W'(vpd_pkg::HDR_BYTES));
  assign count_inc = (byte_count == vpd_pkg::COUNT_MAX) ? byte_count
                                                        : byte_count + 1'b1;

  // Header bytes as they stand after this byte is taken in
  always_comb begin
    for (int k = 0; k < vpd_pkg::HDR_BYTES; k++) begin
      hdr_next[k] = (in_header && byte_count[vpd_pkg::HDR_IDX_W-1:0] ==
                     vpd_pkg::HDR_IDX_W'(k)) ? data_byte : hdr[k];
    end
  end

  assign magic_next  = {hdr_next[3], hdr_next[2], hdr_next[1], hdr_next[0]};
  assign length_next = {hdr_next[7], hdr_next[6]};

  // Verdict checks in priority order; a saturated count never matches
  always_comb begin
    if (count_inc < vpd_pkg::COUNT_W'(vpd_pkg::HDR_BYTES)) begin
      verdict_status = vpd_pkg::ST_SHORT;
    end else if (magic_next != magic_word) begin
      verdict_status = vpd_pkg::ST_BAD_MAGIC;
    end else if (hdr_next[4] != expected_version) begin
      verdict_status = vpd_pkg::ST_BAD_VER;
    end else if (length_next == '0 || length_next > max_payload) begin
      verdict_status = vpd_pkg::ST_BAD_LEN;
    end else if (count_inc != vpd_pkg::COUNT_W'(vpd_pkg::HDR_BYTES) +
                              vpd_pkg::COUNT_W'(length_next)) begin
      verdict_status = vpd_pkg::ST_SIZE_MISM;
    end else begin
      verdict_status = vpd_pkg::ST_OK;
    end
  end

  always_comb begin
    payload_res              = '0;
    payload_res.kind         = vpd_pkg::KIND_PAYLOAD;
    payload_res.payload_byte = data_byte;
    payload_res.end_of_run   = !end_of_packet;

    verdict_res                 = '0;
    verdict_res.kind            = vpd_pkg::KIND_VERDICT;
    verdict_res.status          = verdict_status;
    verdict_res.flags           = hdr_next[5];
    verdict_res.payload_length  = length_next;
    verdict_res.room_id         = {hdr_next[11], hdr_next[10], hdr_next[9], hdr_next[8]};
    verdict_res.source_id       = {hdr_next[15], hdr_next[14], hdr_next[13], hdr_next[12]};
    verdict_res.sequence_number = {hdr_next[19], hdr_next[18], hdr_next[17], hdr_next[16]};
    verdict_res.time_stamp      = {hdr_next[23], hdr_next[22], hdr_next[21], hdr_next[20]};
    verdict_res.end_of_run      = 1'b1;

    first_res = in_header ? verdict_res : payload_res;
    n_results = vpd_pkg::QCNT_W'(!in_header) + vpd_pkg::QCNT_W'(end_of_packet);
  end

  // Packet state: advance on every byte, clear after the verdict
  always_ff @(posedge clk) begin
    if (rst) begin
      byte_count <= '0;
      for (int k = 0; k < vpd_pkg::HDR_BYTES; k++) begin
        hdr[k] <= '0;
      end
    end else if (in_acc) begin
      if (end_of_packet) begin
        byte_count <= '0;
        for (int k = 0; k < vpd_pkg::HDR_BYTES; k++) begin
          hdr[k] <= '0;
        end
      end else begin
        byte_count <= count_inc;
        for (int k = 0; k < vpd_pkg::HDR_BYTES; k++) begin
          hdr[k] <= hdr_next[k];
        end
      end
    end
  end

  // Queue storage: the payload result (or lone verdict) goes first, the
  // trailing verdict into the following slot
  always_ff @(posedge clk) begin
    if (in_acc && n_results != '0) begin
      queue[wr_ptr] <= first_res;
      if (n_results == vpd_pkg::QCNT_W'(2)) begin
        queue[wr_ptr + 1'b1] <= verdict_res;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr  <= '0;
      rd_ptr  <= '0;
      q_count <= '0;
    end else begin
      if (in_acc) begin
        wr_ptr <= wr_ptr + n_results[vpd_pkg::QPTR_W-1:0];
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      q_count <= q_count + (in_acc ? n_results : '0) - vpd_pkg::QCNT_W'(pop);
    end
  end

  assign result_kind     = queue[rd_ptr].kind;
  assign payload_byte    = queue[rd_ptr].payload_byte;
  assign status          = queue[rd_ptr].status;
  assign flags           = queue[rd_ptr].flags;
  assign payload_length  = queue[rd_ptr].payload_length;
  assign room_id         = queue[rd_ptr].room_id;
  assign source_id       = queue[rd_ptr].source_id;
  assign sequence_number = queue[rd_ptr].sequence_number;
  assign time_stamp      = queue[rd_ptr].time_stamp;
  assign end_of_run      = queue[rd_ptr].end_of_run;

  // Checks
  a_queue_bound: assert property (@(posedge clk) disable iff (rst)
    q_count <= vpd_pkg::QCNT_W'(vpd_pkg::QUEUE_DEPTH))
    else $error("result queue overflow");

  a_eop_clears: assert property (@(posedge clk) disable iff (rst)
    in_acc && end_of_packet |=> byte_count == '0)
    else $error("byte count not cleared after last byte");

  a_count_step: assert property (@(posedge clk) disable iff (rst)
    in_acc && !end_of_packet && in_header |=> byte_count == $past(byte_count) + 1'b1)
    else $error("byte count failed to advance in header");

  a_verdict_ends_run: assert property (@(posedge clk) disable iff (rst)
    out_valid && result_kind == vpd_pkg::KIND_VERDICT |-> end_of_run)
    else $error("verdict without end of run");

endmodule
